[rtl/core/ray_triangle_intersect_assert.svh]
// Assertion macros for the ray/triangle intersection block.
// Used by ray_triangle_intersect.sv; expects i_clk and i_rst_n in scope.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/rti_pkg.sv]
// Shared widths, types and constants of the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

    localparam int CoordW   = 20;
    localparam int CfgW     = 3 * CoordW;
    localparam int CfgIdxW  = 2;
    localparam int EdgeW    = CoordW + 1;
    localparam int ProdW    = 2 * EdgeW;
    localparam int MinorW   = ProdW + 1;
    localparam int LoW      = 22;
    localparam int HiProdW  = EdgeW + MinorW - LoW;
    localparam int LoProdW  = EdgeW + LoW + 1;
    localparam int DetW     = 64;
    localparam int MagW     = DetW - 1;
    localparam int QuoW     = 20;
    localparam int TFrac    = 10;
    localparam int WFrac    = 16;
    localparam int WideW    = DetW + TFrac + 1;
    localparam int WeightW  = 17;
    localparam int PreN     = 8;
    localparam int PipeN    = PreN + QuoW;

    typedef logic signed [CoordW-1:0]  t_coord;
    typedef logic signed [EdgeW-1:0]   t_edge;
    typedef logic signed [ProdW-1:0]   t_prod;
    typedef logic signed [MinorW-1:0]  t_minor;
    typedef logic signed [HiProdW-1:0] t_hprod;
    typedef logic signed [LoProdW-1:0] t_lprod;
    typedef logic signed [DetW-1:0]    t_det;
    typedef logic signed [WideW-1:0]   t_wide;
    typedef logic [MagW-1:0]           t_mag;
    typedef logic [QuoW-1:0]           t_quo;
    typedef logic [WeightW-1:0]        t_weight;

    localparam logic [CfgIdxW-1:0] CFG_CORNER_ZERO = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CORNER_ONE  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CORNER_TWO  = 2'd2;

    localparam t_weight WEIGHT_ONE = t_weight'(1 << WFrac);
    localparam t_quo    T_CAP_POS  = t_quo'((1 << (CoordW - 1)) - 1);
    localparam t_quo    T_CAP_NEG  = t_quo'(1 << (CoordW - 1));

    typedef struct packed {
        t_coord lo;
        t_coord hi;
    } t_lim;

    typedef struct packed {
        logic hit;
        logic tneg;
        logic tsat;
    } t_flag;

    typedef struct packed {
        logic    hit;
        t_coord  t_hit;
        t_weight w_zero;
        t_weight w_one;
        t_weight w_two;
    } t_res;

endpackage

[rtl/core/ray_triangle_intersect.sv]
// Ray against one triangle in fixed point: top level.
// Depends on rti_pkg, rti_div and ray_triangle_intersect_assert.svh.
//
// Usage:
// Write the three corners through i_cfg_we/i_cfg_index/i_cfg_data while idle;
// each register packs x, y, z as signed Q10.10 in bits 19:0, 39:20, 59:40.
// Rays enter on i_valid/o_stall, one transfer per cycle while o_stall is low.
// Results leave on o_valid/i_stall, one per ray, in order.
// A ray passes eight stages of determinant arithmetic (edges, products,
// minors, split products, partial sums, sums, sign, tests), twenty stages of
// the one-bit-per-stage dividers, one result stage and the output register.
// Throughput is one ray per cycle while o_stall is low; the divider pipeline
// sets the depth.
// When the receiver stalls, the result waits in the output register and the
// next one in a skid register; only then does o_stall rise and the whole
// pipeline hold. Nothing is dropped or repeated.
// Reset clears the corners to zero and empties the pipeline.
// A zero determinant or a t outside [t_low, t_high] gives hit 0, all zeros.
`include "ray_triangle_intersect_assert.svh"

module ray_triangle_intersect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rti_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [rti_pkg::CfgW-1:0]            i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rti_pkg::CoordW-1:0]   i_origin_x,
    input  logic signed [rti_pkg::CoordW-1:0]   i_origin_y,
    input  logic signed [rti_pkg::CoordW-1:0]   i_origin_z,
    input  logic signed [rti_pkg::CoordW-1:0]   i_dir_x,
    input  logic signed [rti_pkg::CoordW-1:0]   i_dir_y,
    input  logic signed [rti_pkg::CoordW-1:0]   i_dir_z,
    input  logic signed [rti_pkg::CoordW-1:0]   i_t_low,
    input  logic signed [rti_pkg::CoordW-1:0]   i_t_high,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic signed [rti_pkg::CoordW-1:0]   o_t_hit,
    output logic [rti_pkg::WeightW-1:0]         o_weight_zero,
    output logic [rti_pkg::WeightW-1:0]         o_weight_one,
    output logic [rti_pkg::WeightW-1:0]         o_weight_two
);
    import rti_pkg::*;

    localparam int Nxt1 [3]   = '{1, 2, 0};
    localparam int Nxt2 [3]   = '{2, 0, 1};
    localparam int PairOf [4] = '{0, 0, 1, 2};

    logic [CfgW-1:0] r_corner [3];

    logic   en;
    logic   r_v   [PipeN];
    t_lim   r_lim [PipeN];
    t_flag  r_fl  [QuoW];

    t_coord c_pt [3][3];
    t_coord org  [3];
    t_coord dirv [3];

    t_edge  r1_e1 [3];
    t_edge  r1_e2 [3];
    t_edge  r1_b  [3];
    t_edge  r1_nd [3];
    t_edge  col_u [3][3];
    t_edge  col_v [3][3];

    t_prod  r2_p  [3][3][2];
    t_edge  r2_e1 [3];
    t_edge  r2_b  [3];
    t_minor r3_m  [3][3];
    t_edge  r3_e1 [3];
    t_edge  r3_b  [3];
    t_hprod r4_ph [4][3];
    t_lprod r4_pl [4][3];
    t_det   r5_t  [4][3];
    t_det   r6_det [4];
    t_det   r7_x  [4];
    logic   r7_nz;

    t_mag   r8_det;
    t_mag   r8_amag;
    t_mag   r8_bmag;
    t_mag   r8_tmag;
    t_flag  r8_fl;
    t_flag  n8_fl;
    t_wide  dsc;
    t_wide  tw;

    t_quo   quo_t;
    t_quo   quo_a;
    t_quo   quo_b;

    t_quo   cap;
    t_quo   tm;
    t_coord tq;
    logic   fhit;
    t_res   n_f;
    t_res   r_f;
    logic   r_fv;
    t_res   r_o;
    t_res   r_sk;
    logic   r_ov;
    logic   r_skv;

    assign en      = !r_skv;
    assign o_stall = r_skv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_corner[j] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CORNER_ZERO: r_corner[0] <= i_cfg_data;
                CFG_CORNER_ONE:  r_corner[1] <= i_cfg_data;
                CFG_CORNER_TWO:  r_corner[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                c_pt[j][k] = $signed(r_corner[j][k*CoordW +: CoordW]);
            end
        end
        org[0]  = i_origin_x;
        org[1]  = i_origin_y;
        org[2]  = i_origin_z;
        dirv[0] = i_dir_x;
        dirv[1] = i_dir_y;
        dirv[2] = i_dir_z;
        col_u[0] = r1_e2;
        col_v[0] = r1_nd;
        col_u[1] = r1_b;
        col_v[1] = r1_nd;
        col_u[2] = r1_e2;
        col_v[2] = r1_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PipeN; i++) begin
                r_v[i] <= 1'b0;
            end
            r_fv <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < PipeN; i++) begin
                r_v[i] <= r_v[i-1];
            end
            r_fv <= r_v[PipeN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lim[0] <= '{lo: i_t_low, hi: i_t_high};
            for (int i = 1; i < PipeN; i++) begin
                r_lim[i] <= r_lim[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= t_edge'(c_pt[1][k]) - t_edge'(c_pt[0][k]);
                r1_e2[k] <= t_edge'(c_pt[2][k]) - t_edge'(c_pt[0][k]);
                r1_b[k]  <= t_edge'(org[k]) - t_edge'(c_pt[0][k]);
                r1_nd[k] <= -t_edge'(dirv[k]);
            end
            r2_e1 <= r1_e1;
            r2_b  <= r1_b;
            for (int p = 0; p < 3; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_p[p][k][0] <= t_prod'(col_u[p][Nxt1[k]]) * t_prod'(col_v[p][Nxt2[k]]);
                    r2_p[p][k][1] <= t_prod'(col_u[p][Nxt2[k]]) * t_prod'(col_v[p][Nxt1[k]]);
                    r3_m[p][k] <= t_minor'(r2_p[p][k][0]) - t_minor'(r2_p[p][k][1]);
                end
            end
            r3_e1 <= r2_e1;
            r3_b  <= r2_b;
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_ph[d][k] <= t_hprod'((d == 1) ? r3_b[k] : r3_e1[k])
                        * t_hprod'($signed(r3_m[PairOf[d]][k][MinorW-1:LoW]));
                    r4_pl[d][k] <= t_lprod'((d == 1) ? r3_b[k] : r3_e1[k])
                        * t_lprod'($signed({1'b0, r3_m[PairOf[d]][k][LoW-1:0]}));
                    r5_t[d][k] <= (t_det'(r4_ph[d][k]) <<< LoW) + t_det'(r4_pl[d][k]);
                end
                r6_det[d] <= r5_t[d][0] + r5_t[d][1] + r5_t[d][2];
                r7_x[d]   <= r6_det[0][DetW-1] ? -r6_det[d] : r6_det[d];
            end
            r7_nz   <= (r6_det[0] != '0);
            r8_det  <= t_mag'(r7_x[0]);
            r8_amag <= t_mag'(r7_x[1]);
            r8_bmag <= t_mag'(r7_x[2]);
            r8_tmag <= r7_x[3][DetW-1] ? t_mag'(-r7_x[3]) : t_mag'(r7_x[3]);
            r8_fl   <= n8_fl;
            r_fl[0] <= r8_fl;
            for (int i = 1; i < QuoW; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
            r_f <= n_f;
        end
    end

    always_comb begin
        dsc        = t_wide'(r7_x[0]) <<< TFrac;
        tw         = t_wide'(r7_x[3]);
        n8_fl.hit  = r7_nz && !r7_x[1][DetW-1] && !r7_x[2][DetW-1]
                     && (r7_x[1] <= r7_x[0] - r7_x[2]);
        n8_fl.tneg = r7_x[3][DetW-1];
        n8_fl.tsat = n8_fl.tneg ? ((tw + dsc) <= t_wide'(0)) : (tw >= dsc);
    end

    rti_div #(.DenW(MagW), .QW(QuoW), .Frac(TFrac)) u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_tmag),
        .i_den (r8_det),
        .o_quo (quo_t)
    );

    rti_div #(.DenW(MagW), .QW(QuoW), .Frac(WFrac)) u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_amag),
        .i_den (r8_det),
        .o_quo (quo_a)
    );

    rti_div #(.DenW(MagW), .QW(QuoW), .Frac(WFrac)) u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_bmag),
        .i_den (r8_det),
        .o_quo (quo_b)
    );

    always_comb begin
        cap  = r_fl[QuoW-1].tneg ? T_CAP_NEG : T_CAP_POS;
        tm   = (r_fl[QuoW-1].tsat || (quo_t > cap)) ? cap : quo_t;
        tq   = $signed(r_fl[QuoW-1].tneg ? t_quo'(-tm) : tm);
        fhit = r_fl[QuoW-1].hit && (tq >= r_lim[PipeN-1].lo) && (tq <= r_lim[PipeN-1].hi);
        n_f.hit    = fhit;
        n_f.t_hit  = fhit ? tq : '0;
        n_f.w_one  = fhit ? quo_a[WeightW-1:0] : '0;
        n_f.w_two  = fhit ? quo_b[WeightW-1:0] : '0;
        n_f.w_zero = fhit ? (WEIGHT_ONE - quo_a[WeightW-1:0] - quo_b[WeightW-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            r_ov  <= r_skv || (en && r_fv);
            r_skv <= 1'b0;
        end else if (en && r_fv) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_o <= r_skv ? r_sk : r_f;
        end else if (en && r_fv) begin
            r_sk <= r_f;
        end
    end

    assign o_valid       = r_ov;
    assign o_hit         = r_o.hit;
    assign o_t_hit       = r_o.t_hit;
    assign o_weight_zero = r_o.w_zero;
    assign o_weight_one  = r_o.w_one;
    assign o_weight_two  = r_o.w_two;

    `RTI_ASSERT_IMP(a_skid_behind_out, r_skv, r_ov, "skid full while output empty")
    `RTI_ASSERT_NXT(a_hold_on_skid, r_skv, $stable(r_f), "result stage moved while skid full")
    `RTI_ASSERT_IMP(a_weight_sum, o_valid && o_hit,
        (19'(o_weight_zero) + 19'(o_weight_one) + 19'(o_weight_two)) == 19'(WEIGHT_ONE),
        "barycentric weights do not sum to one")
    `RTI_ASSERT_IMP(a_miss_zero, o_valid && !o_hit,
        (o_t_hit == '0) && (o_weight_zero == '0) && (o_weight_one == '0)
        && (o_weight_two == '0), "miss with nonzero fields")

endmodule

[rtl/core/rti_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Computes floor((num << Frac) / den) over QW bits; depends on rti_pkg.
module rti_div #(
    parameter int DenW = rti_pkg::MagW,
    parameter int QW   = rti_pkg::QuoW,
    parameter int Frac = rti_pkg::TFrac
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DenW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    output logic [QW-1:0]   o_quo
);
    localparam int RemW = DenW + QW;

    logic [RemW-1:0] r_rem [QW];
    logic [DenW-1:0] r_den [QW];
    logic [QW-1:0]   r_quo [QW];
    logic [RemW-1:0] n_rem [QW];
    logic [QW-1:0]   n_quo [QW];
    logic [RemW-1:0] rem_in [QW];
    logic [DenW-1:0] den_in [QW];
    logic [QW-1:0]   quo_in [QW];
    logic [RemW:0]   diff [QW];

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                rem_in[s] = RemW'(i_num) << Frac;
                den_in[s] = i_den;
                quo_in[s] = '0;
            end else begin
                rem_in[s] = r_rem[s-1];
                den_in[s] = r_den[s-1];
                quo_in[s] = r_quo[s-1];
            end
            diff[s] = {1'b0, rem_in[s]} - ({1'b0, RemW'(den_in[s])} << (QW - 1 - s));
            n_rem[s] = diff[s][RemW] ? rem_in[s] : diff[s][RemW-1:0];
            n_quo[s] = quo_in[s] | (QW'(!diff[s][RemW]) << (QW - 1 - s));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= den_in[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
